/* src/ucid_pkg.sv */
// Shared constants and sizes for the unique code ID assigner.
// No dependencies; used by the top level and the code table RAM instance.
package ucid_pkg;

  localparam int unsigned MAX_CODES = 256;
  localparam int unsigned CODE_W    = 64;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned ADDR_W    = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int unsigned COUNT_W   = $clog2(MAX_CODES + 1);

  // IDs at or above this value are never handed out
  localparam logic [ID_W-1:0] ID_LIMIT = 16'hFFFF;

endpackage

/* src/ucid_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ucid_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/unique_code_id_assigner.sv */
// Flow: a request is accepted only while idle; the scan reads table entries from index 0
// up to a hit or the entry count, then the result waits until the result side can take it.
// Only one request is in flight at a time; the table RAM read port scans one entry per
// cycle, in order of arrival.
// Reset: entry count, start_id and all handshake state clear; table contents stay
// undefined and are only read below the entry count. No clearing pass is needed.
module unique_code_id_assigner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: start_id
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] code
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] id
  output logic [1:0]  m_axis_tuser    // [0] is_new, [1] error
);

  localparam int unsigned AW = ucid_pkg::ADDR_W;
  localparam int unsigned CW = ucid_pkg::COUNT_W;
  localparam int unsigned IW = ucid_pkg::ID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [IW-1:0]                start_id_q;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                issue_idx_q, issue_idx_d;
  logic [AW-1:0]                cmp_idx_q, cmp_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         hit_q, hit_d;
  logic [ucid_pkg::CODE_W-1:0]  code_q;
  logic [ucid_pkg::CODE_W-1:0]  rd_data;

  logic                         m_valid_q, m_valid_d;
  logic [IW-1:0]                out_id_q;
  logic                         out_new_q, out_err_q;

  logic                         issue, hit_now, out_free, in_acc;
  logic [CW-1:0]                base;
  logic [IW:0]                  sum;
  logic                         err, insert, done_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign issue   = (state_q == ST_SCAN) && (issue_idx_q != count_q) && !hit_now;
  assign hit_now = cmp_vld_q && (rd_data == code_q);

  // decision for the finished search
  assign base   = hit_q ? CW'(cmp_idx_q) : count_q;
  assign sum    = {1'b0, start_id_q} + (IW+1)'(base);
  assign err    = (!hit_q && (count_q == CW'(ucid_pkg::MAX_CODES)))
               || (sum >= {1'b0, ucid_pkg::ID_LIMIT});
  assign insert = !hit_q && !err;
  assign done_fire = (state_q == ST_DONE) && out_free;

  ucid_ram #(
    .WIDTH(ucid_pkg::CODE_W),
    .DEPTH(ucid_pkg::MAX_CODES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (done_fire && insert),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(code_q),
    .re_i   (issue),
    .raddr_i(issue_idx_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    issue_idx_d = issue_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    count_d     = count_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          issue_idx_d = '0;
          hit_d       = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = issue;
        if (issue) begin
          issue_idx_d = issue_idx_q + CW'(1);
          cmp_idx_d   = issue_idx_q[AW-1:0];
        end
        if (hit_now) begin
          hit_d   = 1'b1;
          state_d = ST_DONE;
        end else if (!issue && !cmp_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (insert) begin
            count_d = count_q + CW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_id_q  <= '0;
      count_q     <= '0;
      issue_idx_q <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_idx_q <= issue_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      m_valid_q   <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        start_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (in_acc) begin
      code_q <= s_axis_tdata;
    end
    if (done_fire) begin
      out_id_q  <= err ? '0 : sum[IW-1:0];
      out_new_q <= insert;
      out_err_q <= err;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = {out_err_q, out_new_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ucid_pkg::MAX_CODES))
    else $error("entry count beyond table depth");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_err_q) |-> (!out_new_q && (out_id_q == '0)))
    else $error("error result carries id or new mark");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && insert) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not advance entry count");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_fire && insert) |=> (count_q == $past(count_q)))
    else $error("entry count changed without insert");
`endif

endmodule
